@@ src/o0esc_pkg.sv @@
// Shared types and constants for the order-0 escape model encoder.
// Holds the controller/datapath command and status structs and the fixed field widths.
// No dependencies.
package o0esc_pkg;

    // Fixed field widths.
    localparam int SYM_W     = 8;
    localparam int ALPHA_W   = 9;
    localparam int CNT_W     = 14;
    localparam int ESC_W     = 9;
    localparam int ZERO_W    = 9;
    localparam int RANGE_W   = 14;
    localparam int M_TDATA_W = 48;

    // Model constants.
    localparam logic [CNT_W-1:0]   HALVE_LIMIT = 14'd16000;
    localparam logic [CNT_W-1:0]   HALF_LIMIT  = 14'd8000;
    localparam logic [ESC_W-1:0]   ESC_CAP     = 9'd383;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd256;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_START,
        OP_SCAN,
        OP_UPDATE,
        OP_HSTART,
        OP_HREAD,
        OP_HCOMMIT
    } op_t;

    // Kind of result loaded into the output register.
    typedef enum logic [1:0] {
        OUT_HIT,
        OUT_ESC,
        OUT_NEW,
        OUT_BAD
    } out_kind_t;

    typedef struct packed {
        op_t       op;
        logic      out_load;
        out_kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic in_bad;
        logic scan_end;
        logic mem_end;
        logic hit;
        logic over_limit;
    } stat_t;

endpackage

@@ src/order0_escape_model_encoder.sv @@
// Top level of the order-0 escape model encoder: stream ports and packing.
// Instantiates o0esc_ctrl and o0esc_dpath; depends on o0esc_pkg.
//
// The encoder takes one symbol at a time and returns one range (seen symbol) or two
// ranges (escape, then the uniform range among unseen symbols). Each symbol inside
// the alphabet walks the count memory once over the effective alphabet
// n = min(alphabet_size, MAX_SYMBOLS), one entry per cycle through its single
// read port, before its ranges are output; the output side can stall them. A
// symbol outside the alphabet skips the walk and returns to ready once its
// result is taken. When the total count passes 16000 a halving pass over all
// MAX_SYMBOLS entries runs before the next item is accepted. After reset a
// clearing pass over all MAX_SYMBOLS entries runs before the first item is
// accepted; configuration writes are taken at any time.
module order0_escape_model_encoder #(
    parameter int MAX_SYMBOLS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,   // alphabet_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // symbol[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // range_low[13:0], range_high[27:14], range_total[41:28]
    output logic        m_tlast,     // last
    output logic [0:0]  m_tuser      // bad_symbol[0]
);
    import o0esc_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic [RANGE_W-1:0] range_low, range_high, range_total;
    logic               bad_symbol;

    o0esc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    o0esc_dpath #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_symbol   (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .range_low   (range_low),
        .range_high  (range_high),
        .range_total (range_total),
        .range_last  (m_tlast),
        .bad_symbol  (bad_symbol)
    );

    // Pack the result item, first field in the lowest bits.
    assign m_tdata = {6'b0, range_total, range_high, range_low};
    assign m_tuser = bad_symbol;

endmodule

@@ src/o0esc_ctrl.sv @@
// Controller state machine for the order-0 escape model encoder.
// Sequences clearing, table scan, result output, model update and halving.
// Depends on o0esc_pkg.
module o0esc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  o0esc_pkg::stat_t stat,
    output o0esc_pkg::cmd_t  cmd
);
    import o0esc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_SCAN_TAIL,
        S_DECIDE,
        S_OUT_ESC,
        S_OUT_LAST,
        S_OUT_BAD,
        S_UPDATE,
        S_CHECK,
        S_HALVE,
        S_HALVE_TAIL,
        S_HCOMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

    // Next-state and command logic.
    always_comb
    begin
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd.op        = OP_NONE;
        cmd.out_load  = 1'b0;
        cmd.out_kind  = OUT_BAD;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.mem_end)
                begin
                    state_next    = S_IDLE;
                    s_tready_next = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    s_tready_next = 1'b0;
                    if (stat.in_bad)
                    begin
                        cmd.out_load  = 1'b1;
                        cmd.out_kind  = OUT_BAD;
                        m_tvalid_next = 1'b1;
                        state_next    = S_OUT_BAD;
                    end
                    else
                    begin
                        cmd.op     = OP_START;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (stat.scan_end)
                begin
                    state_next = S_SCAN_TAIL;
                end
            end
            S_SCAN_TAIL:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.out_load  = 1'b1;
                m_tvalid_next = 1'b1;
                if (stat.hit)
                begin
                    cmd.out_kind = OUT_HIT;
                    state_next   = S_OUT_LAST;
                end
                else
                begin
                    cmd.out_kind = OUT_ESC;
                    state_next   = S_OUT_ESC;
                end
            end
            S_OUT_ESC:
            begin
                if (m_tready)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_NEW;
                    state_next   = S_OUT_LAST;
                end
            end
            S_OUT_LAST:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    state_next    = S_UPDATE;
                end
            end
            S_OUT_BAD:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    s_tready_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_UPDATE:
            begin
                cmd.op     = OP_UPDATE;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.over_limit)
                begin
                    cmd.op     = OP_HSTART;
                    state_next = S_HALVE;
                end
                else
                begin
                    s_tready_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_HALVE:
            begin
                cmd.op = OP_HREAD;
                if (stat.mem_end)
                begin
                    state_next = S_HALVE_TAIL;
                end
            end
            S_HALVE_TAIL:
            begin
                state_next = S_HCOMMIT;
            end
            S_HCOMMIT:
            begin
                cmd.op        = OP_HCOMMIT;
                s_tready_next = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // State and registered handshake outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef ASSERT_OFF
    // The block works on one item at a time: it never takes input while a result waits.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready_reg && m_tvalid_reg))
        else $error("input ready while a result is pending");

    // A symbol outside the alphabet produces a result in the very next cycle.
    a_bad_next: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready_reg && stat.in_bad) |=> (m_tvalid_reg && state_reg == S_OUT_BAD))
        else $error("bad symbol did not produce a result");

    // The halving and clearing passes run with both channels closed.
    a_halve_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HALVE || state_reg == S_CLEAR) |-> (!s_tready_reg && !m_tvalid_reg))
        else $error("channel open during a table pass");
`endif

endmodule

@@ src/o0esc_dpath.sv @@
// Datapath for the order-0 escape model encoder: count memory, scan accumulators,
// escape and total counters, alphabet register and the output register.
// Depends on o0esc_pkg.
module o0esc_dpath #(
    parameter int MAX_SYMBOLS = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [o0esc_pkg::ALPHA_W-1:0]       cfg_wdata,
    input  logic [o0esc_pkg::SYM_W-1:0]         in_symbol,
    input  o0esc_pkg::cmd_t                     cmd,
    output o0esc_pkg::stat_t                    stat,
    output logic [o0esc_pkg::RANGE_W-1:0]       range_low,
    output logic [o0esc_pkg::RANGE_W-1:0]       range_high,
    output logic [o0esc_pkg::RANGE_W-1:0]       range_total,
    output logic                                range_last,
    output logic                                bad_symbol
);
    import o0esc_pkg::*;

    localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int CW = (AW + 1 > ALPHA_W) ? AW + 1 : ALPHA_W;
    localparam logic [CW-1:0] MAX_C    = CW'(MAX_SYMBOLS);
    localparam logic [AW-1:0] LAST_ADR = AW'(MAX_SYMBOLS - 1);

    // Count memory and its registered read port.
    logic [CNT_W-1:0] mem [MAX_SYMBOLS];
    logic [CNT_W-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr_reg;
    logic             scan_rd_reg;
    logic             halve_rd_reg;

    logic [AW-1:0]      addr_reg, addr_next;
    logic [SYM_W-1:0]   sym_reg;
    logic [CNT_W-1:0]   lo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [ZERO_W-1:0]  z_reg;
    logic [ZERO_W-1:0]  zt_reg;
    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   newtot_reg;
    logic [ESC_W-1:0]   esc_reg, esc_next;
    logic [ALPHA_W-1:0] alpha_reg;

    logic [RANGE_W-1:0] out_low_reg, out_high_reg, out_total_reg;
    logic               out_last_reg, out_bad_reg;

    logic [CW-1:0]    eff_n;
    logic [CW-1:0]    alpha_ext;
    logic [CW-1:0]    sym_ext;
    logic [CW-1:0]    rd_addr_ext;
    logic [CW-1:0]    addr_ext;
    logic [AW-1:0]    sym_addr;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [CNT_W-1:0] mem_wd;
    logic [CNT_W-1:0] esc14;
    logic [CNT_W-1:0] half_data;

    // Effective alphabet and address comparisons.
    assign alpha_ext   = CW'(alpha_reg);
    assign eff_n       = (alpha_ext < MAX_C) ? alpha_ext : MAX_C;
    assign sym_ext     = CW'(sym_reg);
    assign sym_addr    = sym_ext[AW-1:0];
    assign rd_addr_ext = CW'(rd_addr_reg);
    assign addr_ext    = CW'(addr_reg);
    assign esc14       = CNT_W'(esc_reg);
    assign half_data   = rd_data_reg >> 1;

    assign stat.in_bad     = CW'(in_symbol) >= eff_n;
    assign stat.scan_end   = addr_ext == (eff_n - CW'(1));
    assign stat.mem_end    = addr_reg == LAST_ADR;
    assign stat.hit        = cnt_reg != '0;
    assign stat.over_limit = total_reg > HALVE_LIMIT;

    // Single write port: halving write-back, clearing pass or count update.
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = addr_reg;
        mem_wd = '0;
        priority if (halve_rd_reg)
        begin
            mem_we = 1'b1;
            mem_wa = rd_addr_reg;
            mem_wd = half_data;
        end
        else if (cmd.op == OP_CLEAR)
        begin
            mem_we = 1'b1;
            mem_wa = addr_reg;
            mem_wd = '0;
        end
        else if (cmd.op == OP_UPDATE)
        begin
            mem_we = 1'b1;
            mem_wa = sym_addr;
            mem_wd = cnt_reg + CNT_W'(1);
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[addr_reg];
        rd_addr_reg <= addr_reg;
    end

    // Address counter for the scan, clearing and halving sweeps.
    always_comb
    begin
        addr_next = addr_reg;
        unique case (cmd.op)
            OP_START, OP_HSTART:
            begin
                addr_next = '0;
            end
            OP_CLEAR, OP_SCAN, OP_HREAD:
            begin
                addr_next = stat.mem_end ? '0 : addr_reg + AW'(1);
            end
            default:
            begin
                addr_next = addr_reg;
            end
        endcase
    end

    // Escape count update after a symbol is coded.
    always_comb
    begin
        esc_next = esc_reg;
        priority if (cnt_reg == '0)
        begin
            if (esc_reg < ESC_CAP)
            begin
                esc_next = esc_reg + ESC_W'(1);
            end
        end
        else if (cnt_reg == CNT_W'(1) && esc_reg > ESC_W'(1))
        begin
            esc_next = esc_reg - ESC_W'(1);
        end
        else
        begin
            esc_next = esc_reg;
        end
    end

    // Control registers: sweep address, read flags, model counters, alphabet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            scan_rd_reg  <= 1'b0;
            halve_rd_reg <= 1'b0;
            total_reg    <= '0;
            esc_reg      <= ESC_W'(1);
            alpha_reg    <= ALPHA_RESET;
        end
        else
        begin
            addr_reg     <= addr_next;
            scan_rd_reg  <= cmd.op == OP_SCAN;
            halve_rd_reg <= cmd.op == OP_HREAD;
            if (cfg_we)
            begin
                alpha_reg <= cfg_wdata;
            end
            if (cmd.op == OP_UPDATE)
            begin
                total_reg <= total_reg + CNT_W'(1);
                esc_reg   <= esc_next;
            end
            else if (cmd.op == OP_HCOMMIT)
            begin
                total_reg <= newtot_reg;
            end
        end
    end

    // Scan accumulators and halving sum.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_START)
        begin
            sym_reg <= in_symbol;
            lo_reg  <= '0;
            cnt_reg <= '0;
            z_reg   <= '0;
            zt_reg  <= '0;
        end
        else if (scan_rd_reg)
        begin
            if (rd_addr_ext < sym_ext)
            begin
                lo_reg <= lo_reg + rd_data_reg;
                if (rd_data_reg == '0)
                begin
                    z_reg <= z_reg + ZERO_W'(1);
                end
            end
            if (rd_addr_ext == sym_ext)
            begin
                cnt_reg <= rd_data_reg;
            end
            if (rd_data_reg == '0)
            begin
                zt_reg <= zt_reg + ZERO_W'(1);
            end
        end
        if (cmd.op == OP_HSTART)
        begin
            newtot_reg <= '0;
        end
        else if (halve_rd_reg)
        begin
            newtot_reg <= newtot_reg + half_data;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            unique case (cmd.out_kind)
                OUT_HIT:
                begin
                    out_low_reg   <= esc14 + lo_reg;
                    out_high_reg  <= esc14 + lo_reg + cnt_reg;
                    out_total_reg <= esc14 + total_reg;
                    out_last_reg  <= 1'b1;
                    out_bad_reg   <= 1'b0;
                end
                OUT_ESC:
                begin
                    out_low_reg   <= '0;
                    out_high_reg  <= esc14;
                    out_total_reg <= esc14 + total_reg;
                    out_last_reg  <= 1'b0;
                    out_bad_reg   <= 1'b0;
                end
                OUT_NEW:
                begin
                    out_low_reg   <= RANGE_W'(z_reg);
                    out_high_reg  <= RANGE_W'(z_reg) + RANGE_W'(1);
                    out_total_reg <= RANGE_W'(zt_reg);
                    out_last_reg  <= 1'b1;
                    out_bad_reg   <= 1'b0;
                end
                OUT_BAD:
                begin
                    out_low_reg   <= '0;
                    out_high_reg  <= '0;
                    out_total_reg <= '0;
                    out_last_reg  <= 1'b1;
                    out_bad_reg   <= 1'b1;
                end
                default:
                begin
                    out_last_reg <= 1'b1;
                    out_bad_reg  <= 1'b1;
                end
            endcase
        end
    end

    assign range_low   = out_low_reg;
    assign range_high  = out_high_reg;
    assign range_total = out_total_reg;
    assign range_last  = out_last_reg;
    assign bad_symbol  = out_bad_reg;

`ifndef ASSERT_OFF
    // The escape count stays within its band.
    a_esc_band: assert property (@(posedge clk) disable iff (!rst_n)
        (esc_reg != '0) && (esc_reg <= ESC_CAP))
        else $error("escape count out of range");

    // An update never carries the total more than one past the halving limit.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_UPDATE) |=> (total_reg <= HALVE_LIMIT + CNT_W'(1)))
        else $error("count total ran past the halving limit");

    // After a halving pass the recomputed total is at most half the limit.
    a_halved_total: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_HCOMMIT) |=> (total_reg <= HALF_LIMIT))
        else $error("halved total too large");
`endif

endmodule

@@ dv/order0_escape_model_encoder_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the order-0 escape model encoder.
// It drives symbols, predicts the coder ranges and checks every range item at the output.
// Depends only on o0esc_pkg and the encoder RTL.
module order0_escape_model_encoder_tb;

    localparam int MAX_SYM        = 256;
    localparam int ALPHA_AT_RESET = 256;
    localparam int COUNT_LIMIT    = 16000;
    localparam int ESC_MAX        = 383;
    localparam int SETTLE_CYC     = MAX_SYM + 40;
    localparam int LONG_HOLD      = 600;
    localparam int PRINT_CAP      = 50;
    localparam int DATA_W         = o0esc_pkg::M_TDATA_W;
    localparam int RW             = o0esc_pkg::RANGE_W;

    typedef enum logic
    {
        STIM_SYMBOL,
        STIM_ALPHABET
    } stim_kind_t;

    typedef struct
    {
        stim_kind_t kind;
        logic [8:0] value;
    } stim_t;

    typedef struct packed
    {
        logic [RW-1:0] lo;
        logic [RW-1:0] hi;
        logic [RW-1:0] total;
        logic          is_last;
        logic          is_bad;
    } code_range_t;

    // Clock, reset and block ports.
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [8:0]        cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;    // symbol[7:0]
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DATA_W-1:0] m_tdata;           // range_low[13:0], range_high[27:14], range_total[41:28]
    logic              m_tlast;           // last
    logic [0:0]        m_tuser;           // bad_symbol[0]

    // Shadow of the frequency model.
    logic [13:0]       sym_count [MAX_SYM];
    int unsigned       count_sum;
    int unsigned       esc_count;
    int unsigned       alpha_size;

    // Pending symbols and writes, and ranges still owed by the block.
    stim_t             pending[$];
    code_range_t       expected_ranges[$];

    // Flow control of both sides.
    bit                tx_jitter = 1'b0;
    bit                rx_jitter = 1'b0;
    bit                hold_req  = 1'b0;
    int unsigned       tx_gap;
    int unsigned       rx_stall;
    int unsigned       quiet_cyc;

    // Run statistics.
    int unsigned       n_items   = 0;
    int unsigned       n_results = 0;
    int unsigned       n_bad     = 0;
    int unsigned       n_new     = 0;
    int unsigned       n_halve   = 0;
    int unsigned       errors    = 0;

    order0_escape_model_encoder #(
        .MAX_SYMBOLS (MAX_SYM)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #4 clk = ~clk;

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Codes one symbol against the shadow model, queues its ranges and updates the model.
    function automatic void encode_symbol(input logic [7:0] sym);
        int unsigned n;
        int unsigned below;
        int unsigned zeros_below;
        int unsigned zeros_all;
        code_range_t r;
        n = (alpha_size < MAX_SYM) ? alpha_size : MAX_SYM;
        n_items++;
        if (sym >= n)
        begin
            r = '0;
            r.is_last = 1'b1;
            r.is_bad  = 1'b1;
            expected_ranges.push_back(r);
            n_bad++;
            return;
        end
        r.is_bad = 1'b0;
        if (sym_count[sym] != 0)
        begin
            // Seen symbol: one range above the escape slot and all lower symbols.
            below = esc_count;
            for (int i = 0; i < sym; i++)
                below += sym_count[i];
            r.lo      = RW'(below);
            r.hi      = RW'(below + sym_count[sym]);
            r.total   = RW'(esc_count + count_sum);
            r.is_last = 1'b1;
            expected_ranges.push_back(r);
        end
        else
        begin
            // New symbol: escape range, then a flat range over the unseen symbols.
            zeros_below = 0;
            zeros_all   = 0;
            for (int i = 0; i < n; i++)
            begin
                if (sym_count[i] == 0)
                begin
                    zeros_all++;
                    if (i < sym)
                        zeros_below++;
                end
            end
            r.lo      = '0;
            r.hi      = RW'(esc_count);
            r.total   = RW'(esc_count + count_sum);
            r.is_last = 1'b0;
            expected_ranges.push_back(r);
            r.lo      = RW'(zeros_below);
            r.hi      = RW'(zeros_below + 1);
            r.total   = RW'(zeros_all);
            r.is_last = 1'b1;
            expected_ranges.push_back(r);
            n_new++;
        end

        // Model update, with the escape count kept between one and its cap.
        if (sym_count[sym] == 0)
        begin
            if (esc_count < ESC_MAX)
                esc_count++;
        end
        else if (sym_count[sym] == 1 && esc_count > 1)
        begin
            esc_count--;
        end
        sym_count[sym] = sym_count[sym] + 14'd1;
        count_sum++;
        if (count_sum > COUNT_LIMIT)
        begin
            // Halving covers the whole store, not only the alphabet in use.
            count_sum = 0;
            for (int i = 0; i < MAX_SYM; i++)
            begin
                sym_count[i] = sym_count[i] >> 1;
                count_sum += sym_count[i];
            end
            n_halve++;
        end
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            errors++;
            if (errors <= PRINT_CAP)
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    // Sender: presents symbols, performs register writes once the block is quiet,
    // and runs the shadow model on every accepted item.
    always @(posedge clk or negedge rst_n)
    begin : sender
        logic       nxt_valid;
        logic       nxt_we;
        logic [7:0] nxt_data;
        logic [8:0] nxt_wdata;
        stim_t      head;
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            cfg_we    <= 1'b0;
            cfg_wdata <= '0;
            tx_gap    = 0;
            quiet_cyc = 0;
            for (int i = 0; i < MAX_SYM; i++)
                sym_count[i] = '0;
            count_sum  = 0;
            esc_count  = 1;
            alpha_size = ALPHA_AT_RESET;
        end
        else
        begin
            nxt_valid = s_tvalid;
            nxt_data  = s_tdata;
            nxt_we    = 1'b0;
            nxt_wdata = cfg_wdata;
            if (cfg_we)
                alpha_size = 32'(cfg_wdata);
            if (s_tvalid && s_tready)
            begin
                encode_symbol(s_tdata);
                nxt_valid = 1'b0;
                tx_gap    = tx_jitter ? pick_gap() : 0;
            end
            if (s_tvalid || expected_ranges.size() != 0)
                quiet_cyc = 0;
            else
                quiet_cyc++;

            if (!nxt_valid)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap--;
                end
                else if (pending.size() != 0)
                begin
                    if (pending[0].kind == STIM_SYMBOL)
                    begin
                        head      = pending.pop_front();
                        nxt_valid = 1'b1;
                        nxt_data  = head.value[7:0];
                    end
                    else if (quiet_cyc >= SETTLE_CYC)
                    begin
                        // The block has finished any update or halving pass by now.
                        head      = pending.pop_front();
                        nxt_we    = 1'b1;
                        nxt_wdata = head.value;
                        quiet_cyc = 0;
                    end
                end
            end
            s_tvalid  <= nxt_valid;
            s_tdata   <= nxt_data;
            cfg_we    <= nxt_we;
            cfg_wdata <= nxt_wdata;
        end
    end

    // Receiver: checks each range item against the oldest expectation and
    // throttles m_tready, including one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        code_range_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (expected_ranges.size() == 0)
                begin
                    errors++;
                    if (errors <= PRINT_CAP)
                        $display("%0t ns: range item with none expected, expected nothing, got %h",
                                 $time, m_tdata);
                end
                else
                begin
                    want = expected_ranges.pop_front();
                    check_field("range_low", want.lo, m_tdata[13:0]);
                    check_field("range_high", want.hi, m_tdata[27:14]);
                    check_field("range_total", want.total, m_tdata[41:28]);
                    check_field("last", want.is_last, m_tlast);
                    check_field("bad_symbol", want.is_bad, m_tuser[0]);
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                rx_stall = LONG_HOLD;
            end
            if (rx_stall != 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (rx_jitter)
                    rx_stall = pick_gap();
            end
        end
    end

    task automatic push_symbol(input logic [7:0] sym);
        stim_t e;
        e.kind  = STIM_SYMBOL;
        e.value = {1'b0, sym};
        pending.push_back(e);
    endtask

    task automatic push_alphabet(input logic [8:0] size);
        stim_t e;
        e.kind  = STIM_ALPHABET;
        e.value = size;
        pending.push_back(e);
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || s_tvalid || cfg_we || expected_ranges.size() != 0)
            @(negedge clk);
    endtask

    // One setting of the alphabet followed by random symbols, biased toward a few
    // hot symbols so that counts grow, with some symbols outside the alphabet.
    task automatic random_phase(input logic [8:0] size, input int count, input bit squeeze);
        int unsigned n;
        int unsigned hot;
        int unsigned r;
        logic [7:0]  sym;
        n   = (size < MAX_SYM) ? size : MAX_SYM;
        hot = (n < 4) ? n : 4;
        tx_jitter = squeeze ? 1'b0 : ($urandom_range(0, 3) != 0);
        rx_jitter = ($urandom_range(0, 3) != 0);
        push_alphabet(size);
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (n == 0 || r < 8)
                sym = 8'($urandom_range(0, 255));
            else if (r < 40)
                sym = 8'($urandom_range(0, hot - 1));
            else
                sym = 8'($urandom_range(0, n - 1));
            push_symbol(sym);
        end
        if (squeeze)
        begin
            // Hold the output once symbols flow, so the block backs up into its input.
            while (pending.size() > count - 2)
                @(negedge clk);
            hold_req = 1'b1;
        end
        wait_drained();
    endtask

    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: first and last symbols new and repeated, alternating bit patterns.
        push_symbol(8'd0);   push_symbol(8'd0);   push_symbol(8'd255); push_symbol(8'd255);
        push_symbol(8'd128); push_symbol(8'd1);   push_symbol(8'd254); push_symbol(8'h55);
        push_symbol(8'hAA);  push_symbol(8'd1);   push_symbol(8'h0F);  push_symbol(8'hF0);
        // One-symbol alphabet: only symbol 0 is good.
        push_alphabet(9'd1);
        push_symbol(8'd0);   push_symbol(8'd1);   push_symbol(8'd255); push_symbol(8'd0);
        // Empty alphabet: every symbol is out of range.
        push_alphabet(9'd0);
        push_symbol(8'd0);   push_symbol(8'd255); push_symbol(8'd128);
        // Oversized setting falls back to the full alphabet.
        push_alphabet(9'd511);
        push_symbol(8'd255); push_symbol(8'd7);
        push_alphabet(9'd2);
        push_symbol(8'd1);   push_symbol(8'd2);   push_symbol(8'd0);
        wait_drained();

        // Random phases over a spread of alphabet sizes, small and large.
        random_phase(9'd256, 150, 1'b0);
        random_phase(9'd3,   250, 1'b0);
        random_phase(9'd16,  250, 1'b1);
        random_phase(9'd511, 100, 1'b0);
        random_phase(9'd1,   100, 1'b0);
        random_phase(9'd2,   200, 1'b0);
        random_phase(9'd64,  150, 1'b0);
        random_phase(9'd0,    30, 1'b0);
        random_phase(9'd300, 100, 1'b0);
        random_phase(9'd200, 150, 1'b0);
        random_phase(9'd9,   250, 1'b0);
        random_phase(9'd128, 100, 1'b0);
        random_phase(9'd256,  60, 1'b0);

        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);

        if (expected_ranges.size() != 0)
        begin
            errors++;
            $display("%0t ns: ranges never produced, expected %0d more, got 0",
                     $time, expected_ranges.size());
        end
        $display("Coded %0d symbols (%0d new, %0d outside the alphabet), %0d ranges checked,",
                 n_items, n_new, n_bad, n_results);
        $display("%0d halving passes; alphabets 0 to 511, random stalls, one long output hold.",
                 n_halve);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin : watchdog
        #160_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ order0_escape_model_encoder.f @@
src/o0esc_pkg.sv
src/o0esc_ctrl.sv
src/o0esc_dpath.sv
src/order0_escape_model_encoder.sv
dv/order0_escape_model_encoder_tb.sv
